FILE: src/srv_pkg.sv
// Shared constants and types for the refraction vector block.
package srv_pkg;

   localparam int FRAC              = 24;  // internal fraction bits
   localparam int IW                = 25;  // internal component width
   localparam int ETA_W             = 27;  // eta, unsigned Q.24, at most 4.0
   localparam int ETA2_W            = 29;  // eta squared, unsigned Q.24
   localparam int INDEX_W           = 16;
   localparam int INDEX_MIN         = 1024;
   localparam int INDEX_RESET       = 4096;
   localparam int DIVD_W            = 37;  // 2^36 plus rounding term
   localparam int DIV_STEPS         = 37;
   localparam int MUL_STEPS         = 27;
   localparam int STEP_CNT_W        = 6;
   localparam int COMPONENT_BITS_DEF = 16;

   typedef struct packed {
      logic              busy;
      logic [ETA_W-1:0]  eta;
      logic [ETA2_W-1:0] eta2;
   } coef_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_MUL  = 3'b100
   } eta_state_type;

endpackage

FILE: src/srv_isqrt.sv
// Pipelined integer square root, one root bit per register stage, with side payload.
module srv_isqrt #(
   parameter int XW = 56,
   parameter int PW = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_vld,
   input  logic [XW-1:0]    in_x,
   input  logic [PW-1:0]    in_pay,
   output logic             out_vld,
   output logic [XW/2-1:0]  out_root,
   output logic [PW-1:0]    out_pay
);

   localparam int RW = XW / 2;
   localparam int TW = XW + 1;

   logic          vld_ff  [RW];
   logic [TW-1:0] rem_ff  [RW];
   logic [RW-1:0] root_ff [RW];
   logic [PW-1:0] pay_ff  [RW];

   for (genvar i = 0; i < RW; i++) begin : g_stage
      localparam int B = RW - 1 - i;
      logic          vld_i;
      logic [TW-1:0] rem_i;
      logic [RW-1:0] root_i;
      logic [PW-1:0] pay_i;
      logic [TW-1:0] test;
      logic          ge;

      if (i == 0) begin : g_first
         assign vld_i  = in_vld;
         assign rem_i  = TW'(in_x);
         assign root_i = '0;
         assign pay_i  = in_pay;
      end else begin : g_next
         assign vld_i  = vld_ff[i-1];
         assign rem_i  = rem_ff[i-1];
         assign root_i = root_ff[i-1];
         assign pay_i  = pay_ff[i-1];
      end

      // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
      assign test = (TW'(root_i) << (B + 1)) + (TW'(1) << (2 * B));
      assign ge   = rem_i >= test;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_i;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= ge ? rem_i - test : rem_i;
            root_ff[i] <= ge ? (root_i | (RW'(1) << B)) : root_i;
            pay_ff[i]  <= pay_i;
         end
      end
   end

   assign out_vld  = vld_ff[RW-1];
   assign out_root = root_ff[RW-1];
   assign out_pay  = pay_ff[RW-1];

endmodule

FILE: src/srv_eta.sv
// Index register with a serial reciprocal and squaring sequencer for eta and eta^2.
module srv_eta (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [srv_pkg::INDEX_W-1:0]  csr_data,
   output srv_pkg::coef_type            coef
);

   localparam int W  = srv_pkg::INDEX_W;
   localparam int DW = srv_pkg::DIVD_W;
   localparam int EW = srv_pkg::ETA_W;
   localparam int AW = 2 * EW - 1;
   localparam int CW = srv_pkg::STEP_CNT_W;

   srv_pkg::eta_state_type state_ff, state_in;
   logic [W-1:0]               idx_ff, idx_in;
   logic [W-1:0]               rem_ff, rem_in;
   logic [DW-1:0]              num_ff, num_in;
   logic [EW-1:0]              quo_ff, quo_in;
   logic [EW-1:0]              mplier_ff, mplier_in;
   logic [AW-1:0]              mcand_ff, mcand_in;
   logic [AW-1:0]              acc_ff, acc_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic [EW-1:0]              eta_ff, eta_in;
   logic [srv_pkg::ETA2_W-1:0] eta2_ff, eta2_in;
   logic [W:0]                 trial;
   logic                       ge;
   logic [W-1:0]               idx_cl;

   assign csr_ready = state_ff == srv_pkg::ST_IDLE;
   assign idx_cl    = (csr_data < W'(srv_pkg::INDEX_MIN)) ? W'(srv_pkg::INDEX_MIN) : csr_data;
   assign trial     = {rem_ff, num_ff[DW-1]};
   assign ge        = trial >= {1'b0, idx_ff};

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      rem_in    = rem_ff;
      num_in    = num_ff;
      quo_in    = quo_ff;
      mplier_in = mplier_ff;
      mcand_in  = mcand_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      eta_in    = eta_ff;
      eta2_in   = eta2_ff;
      unique case (state_ff)
         srv_pkg::ST_IDLE: begin
            if (csr_valid) begin
               idx_in   = idx_cl;
               rem_in   = '0;
               quo_in   = '0;
               cnt_in   = '0;
               num_in   = (DW'(1) << (DW - 1)) | DW'(idx_cl >> 1);
               state_in = srv_pkg::ST_DIV;
            end
         end
         srv_pkg::ST_DIV: begin
            // restoring division, one quotient bit per cycle
            rem_in = ge ? W'(trial - {1'b0, idx_ff}) : trial[W-1:0];
            quo_in = {quo_ff[EW-2:0], ge};
            num_in = num_ff << 1;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(srv_pkg::DIV_STEPS - 1)) begin
               eta_in    = quo_in;
               mplier_in = quo_in;
               mcand_in  = AW'(quo_in);
               acc_in    = '0;
               cnt_in    = '0;
               state_in  = srv_pkg::ST_MUL;
            end
         end
         srv_pkg::ST_MUL: begin
            // shift-add square of eta
            acc_in    = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff + CW'(1);
            if (cnt_ff == CW'(srv_pkg::MUL_STEPS - 1)) begin
               eta2_in  = acc_in[srv_pkg::FRAC +: srv_pkg::ETA2_W];
               state_in = srv_pkg::ST_IDLE;
            end
         end
         default: state_in = srv_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srv_pkg::ST_IDLE;
         eta_ff   <= EW'(1) << srv_pkg::FRAC;
         eta2_ff  <= srv_pkg::ETA2_W'(1) << srv_pkg::FRAC;
      end else begin
         state_ff <= state_in;
         eta_ff   <= eta_in;
         eta2_ff  <= eta2_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      rem_ff    <= rem_in;
      num_ff    <= num_in;
      quo_ff    <= quo_in;
      mplier_ff <= mplier_in;
      mcand_ff  <= mcand_in;
      acc_ff    <= acc_in;
      cnt_ff    <= cnt_in;
   end

   assign coef.busy = state_ff != srv_pkg::ST_IDLE;
   assign coef.eta  = eta_ff;
   assign coef.eta2 = eta2_ff;

endmodule

FILE: src/snell_refraction_vector.sv
// Top level: pipelined Snell refraction of a unit direction about a unit normal.
//
//  channel | dir | handshake          | payload
//  req     | in  | req_tvalid/tready  | incident x,y,z and normal x,y,z
//  rsp     | out | rsp_tvalid/tready  | refracted x,y,z; tuser total_reflection
//  csr     | in  | csr_valid/ready    | refractive_index, Q4.12
//
// One ray per cycle while the output is not stalled and no csr write is in progress;
// the two square roots and the normalizing divider are bit-per-stage pipelines.
// A csr write occupies the serial reciprocal/square unit, during which req_tready
// is low. Reset clears the valid bits and sets eta and eta^2 to 1.0.
// A stalled output freezes every stage; nothing is dropped or repeated.
module snell_refraction_vector #(
   parameter int COMPONENT_BITS = srv_pkg::COMPONENT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // incident_x, incident_y, incident_z, normal_x, normal_y, normal_z, zero fill
   input  logic [((6*COMPONENT_BITS+7)/8)*8-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // refracted_x, refracted_y, refracted_z, zero fill
   output logic [((3*COMPONENT_BITS+7)/8)*8-1:0] rsp_tdata,
   // total_reflection
   output logic                          rsp_tuser,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [srv_pkg::INDEX_W-1:0]   csr_data
);

   localparam int CB    = COMPONENT_BITS;
   localparam int FO    = CB - 1;
   localparam int QW    = CB + 1;
   localparam int FRAC  = srv_pkg::FRAC;
   localparam int IW    = srv_pkg::IW;
   localparam int CW    = 28;        // cosi
   localparam int SW    = 30;        // 1 - cosi^2
   localparam int ECW   = 30;        // eta * cosi
   localparam int KW    = 37;        // k before the sign test
   localparam int CFW   = 31;        // coefficient of N
   localparam int MW    = 31;        // magnitude of T
   localparam int X1W   = 56;
   localparam int X2W   = 62;
   localparam int NW    = X2W / 2;
   localparam int DW    = FO + 33;
   localparam int RSP_W = ((3 * CB + 7) / 8) * 8;
   localparam logic signed [CW-1:0] NEG_ONE = CW'(-(1 <<< FRAC));
   localparam logic signed [KW-1:0] ONE_K   = KW'(1 <<< FRAC);
   localparam logic signed [SW-1:0] ONE_S   = SW'(1 <<< FRAC);

   typedef struct packed {
      logic [2:0][IW-1:0]  iv;
      logic [2:0][IW-1:0]  nv;
      logic [ECW-1:0]      ecs;
      logic                tir;
   } sq1_pay_type;

   typedef struct packed {
      logic [2:0][MW-1:0]  mag;
      logic [2:0]          neg;
      logic                tir;
   } sq2_pay_type;

   srv_pkg::coef_type coef;
   logic              en;

   srv_eta u_eta (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .coef      (coef)
   );

   // every stage advances unless the output holds an untaken result
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en && !coef.busy;

   // ---- stage 1: Q.24 conversion and dot-product terms
   logic signed [IW-1:0]   iv_c [3];
   logic signed [IW-1:0]   nv_c [3];
   logic                   p1_vld_ff;
   logic signed [IW-1:0]   p1_iv_ff [3];
   logic signed [IW-1:0]   p1_nv_ff [3];
   logic signed [2*IW-1:0] p1_pd_ff [3];

   for (genvar i = 0; i < 3; i++) begin : g_conv
      logic signed [CB-1:0] raw_i, raw_n;
      assign raw_i = req_tdata[i*CB +: CB];
      assign raw_n = req_tdata[(3+i)*CB +: CB];
      if (FO <= FRAC) begin : g_up
         assign iv_c[i] = IW'(raw_i) <<< (FRAC - FO);
         assign nv_c[i] = IW'(raw_n) <<< (FRAC - FO);
      end else begin : g_down
         assign iv_c[i] = IW'(raw_i >>> (FO - FRAC));
         assign nv_c[i] = IW'(raw_n >>> (FO - FRAC));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
      end else if (en) begin
         p1_vld_ff <= req_tvalid && req_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            p1_iv_ff[i] <= iv_c[i];
            p1_nv_ff[i] <= nv_c[i];
            p1_pd_ff[i] <= iv_c[i] * nv_c[i];
         end
      end
   end

   // ---- stage 2: dot product, clamp, cosi
   logic signed [2*IW+1:0] dot_sum;
   logic signed [CW-1:0]   dot;
   logic                   p2_vld_ff;
   logic signed [CW-1:0]   p2_cosi_ff;
   logic signed [IW-1:0]   p2_iv_ff [3];
   logic signed [IW-1:0]   p2_nv_ff [3];

   assign dot_sum = p1_pd_ff[0] + p1_pd_ff[1] + p1_pd_ff[2];
   assign dot     = CW'(dot_sum >>> FRAC);

   // ---- stage 3: cosi^2 and eta*cosi
   logic                   p3_vld_ff;
   logic signed [2*CW-1:0] p3_cc_ff;
   logic signed [2*CW-1:0] p3_ec_ff;
   logic signed [IW-1:0]   p3_iv_ff [3];
   logic signed [IW-1:0]   p3_nv_ff [3];

   // ---- stage 4: 1 - cosi^2, floored eta*cosi
   logic                   p4_vld_ff;
   logic signed [SW-1:0]   p4_s_ff;
   logic signed [ECW-1:0]  p4_ecs_ff;
   logic signed [IW-1:0]   p4_iv_ff [3];
   logic signed [IW-1:0]   p4_nv_ff [3];

   // ---- stage 5: eta^2 * (1 - cosi^2)
   logic                   p5_vld_ff;
   logic signed [2*SW-1:0] p5_es_ff;
   logic signed [ECW-1:0]  p5_ecs_ff;
   logic signed [IW-1:0]   p5_iv_ff [3];
   logic signed [IW-1:0]   p5_nv_ff [3];

   // ---- stage 6: k and its sign
   logic signed [KW-1:0]   k_c;
   logic                   p6_vld_ff;
   logic [31:0]            p6_k_ff;
   sq1_pay_type            p6_pay_ff;

   assign k_c = ONE_K - KW'(p5_es_ff >>> FRAC);

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
         p4_vld_ff <= 1'b0;
         p5_vld_ff <= 1'b0;
         p6_vld_ff <= 1'b0;
      end else if (en) begin
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
         p4_vld_ff <= p3_vld_ff;
         p5_vld_ff <= p4_vld_ff;
         p6_vld_ff <= p5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p2_cosi_ff <= (dot < NEG_ONE) ? -NEG_ONE : -dot;
         p3_cc_ff   <= p2_cosi_ff * p2_cosi_ff;
         p3_ec_ff   <= $signed({1'b0, coef.eta}) * p2_cosi_ff;
         p4_s_ff    <= ONE_S - SW'(p3_cc_ff >>> FRAC);
         p4_ecs_ff  <= ECW'(p3_ec_ff >>> FRAC);
         p5_es_ff   <= $signed({1'b0, coef.eta2}) * p4_s_ff;
         p5_ecs_ff  <= p4_ecs_ff;
         p6_k_ff    <= (k_c < 0) ? '0 : k_c[31:0];
         p6_pay_ff.tir <= k_c < 0;
         p6_pay_ff.ecs <= p5_ecs_ff;
         for (int i = 0; i < 3; i++) begin
            p2_iv_ff[i] <= p1_iv_ff[i];
            p2_nv_ff[i] <= p1_nv_ff[i];
            p3_iv_ff[i] <= p2_iv_ff[i];
            p3_nv_ff[i] <= p2_nv_ff[i];
            p4_iv_ff[i] <= p3_iv_ff[i];
            p4_nv_ff[i] <= p3_nv_ff[i];
            p5_iv_ff[i] <= p4_iv_ff[i];
            p5_nv_ff[i] <= p4_nv_ff[i];
            p6_pay_ff.iv[i] <= p5_iv_ff[i];
            p6_pay_ff.nv[i] <= p5_nv_ff[i];
         end
      end
   end

   // ---- sqrt(k) in Q.24
   logic                  s1_vld;
   logic [X1W/2-1:0]      s1_root;
   logic [$bits(sq1_pay_type)-1:0] s1_bits;
   sq1_pay_type           s1_pay;

   srv_isqrt #(.XW(X1W), .PW($bits(sq1_pay_type))) u_sqrt_k (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (p6_vld_ff),
      .in_x     ({p6_k_ff, {FRAC{1'b0}}}),
      .in_pay   (p6_pay_ff),
      .out_vld  (s1_vld),
      .out_root (s1_root),
      .out_pay  (s1_bits)
   );
   assign s1_pay = s1_bits;

   // ---- stage 7: coefficient of N
   logic                  p7_vld_ff;
   logic signed [CFW-1:0] p7_coef_ff;
   logic signed [IW-1:0]  p7_iv_ff [3];
   logic signed [IW-1:0]  p7_nv_ff [3];
   logic                  p7_tir_ff;

   // ---- stage 8: I*eta and N*coef
   logic                         p8_vld_ff;
   logic signed [IW+srv_pkg::ETA_W:0] p8_ti_ff [3];
   logic signed [IW+CFW-1:0]     p8_tn_ff [3];
   logic                         p8_tir_ff;

   // ---- stage 9: T and its magnitude
   logic signed [IW+CFW:0]       t_sum [3];
   logic signed [IW+CFW-FRAC:0]  t_v   [3];
   logic                         p9_vld_ff;
   logic [MW-1:0]                p9_mag_ff [3];
   logic [2:0]                   p9_neg_ff;
   logic                         p9_tir_ff;

   // ---- stage 10: squares, stage 11: sum of squares
   logic                  p10_vld_ff;
   logic [2*MW-1:0]       p10_sq_ff [3];
   logic [MW-1:0]         p10_mag_ff [3];
   logic [2:0]            p10_neg_ff;
   logic                  p10_tir_ff;
   logic                  p11_vld_ff;
   logic [X2W-1:0]        p11_ss_ff;
   sq2_pay_type           p11_pay_ff;

   for (genvar i = 0; i < 3; i++) begin : g_tvec
      assign t_sum[i] = p8_ti_ff[i] + p8_tn_ff[i];
      assign t_v[i]   = (IW+CFW-FRAC+1)'(t_sum[i] >>> FRAC);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p7_vld_ff  <= 1'b0;
         p8_vld_ff  <= 1'b0;
         p9_vld_ff  <= 1'b0;
         p10_vld_ff <= 1'b0;
         p11_vld_ff <= 1'b0;
      end else if (en) begin
         p7_vld_ff  <= s1_vld;
         p8_vld_ff  <= p7_vld_ff;
         p9_vld_ff  <= p8_vld_ff;
         p10_vld_ff <= p9_vld_ff;
         p11_vld_ff <= p10_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p7_coef_ff <= CFW'($signed(s1_pay.ecs)) - CFW'(s1_root);
         p7_tir_ff  <= s1_pay.tir;
         p8_tir_ff  <= p7_tir_ff;
         p9_tir_ff  <= p8_tir_ff;
         p10_tir_ff <= p9_tir_ff;
         p10_neg_ff <= p9_neg_ff;
         p11_ss_ff  <= X2W'(p10_sq_ff[0]) + X2W'(p10_sq_ff[1]) + X2W'(p10_sq_ff[2]);
         p11_pay_ff.neg <= p10_neg_ff;
         p11_pay_ff.tir <= p10_tir_ff;
         for (int i = 0; i < 3; i++) begin
            p7_iv_ff[i]   <= $signed(s1_pay.iv[i]);
            p7_nv_ff[i]   <= $signed(s1_pay.nv[i]);
            p8_ti_ff[i]   <= p7_iv_ff[i] * $signed({1'b0, coef.eta});
            p8_tn_ff[i]   <= p7_nv_ff[i] * p7_coef_ff;
            p9_neg_ff[i]  <= t_v[i] < 0;
            p9_mag_ff[i]  <= (t_v[i] < 0) ? MW'(-t_v[i]) : MW'(t_v[i]);
            p10_sq_ff[i]  <= p9_mag_ff[i] * p9_mag_ff[i];
            p10_mag_ff[i] <= p9_mag_ff[i];
            p11_pay_ff.mag[i] <= p10_mag_ff[i];
         end
      end
   end

   // ---- norm of T
   logic                  s2_vld;
   logic [NW-1:0]         s2_root;
   logic [$bits(sq2_pay_type)-1:0] s2_bits;
   sq2_pay_type           s2_pay;

   srv_isqrt #(.XW(X2W), .PW($bits(sq2_pay_type))) u_sqrt_norm (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (p11_vld_ff),
      .in_x     (p11_ss_ff),
      .in_pay   (p11_pay_ff),
      .out_vld  (s2_vld),
      .out_root (s2_root),
      .out_pay  (s2_bits)
   );
   assign s2_pay = s2_bits;

   // ---- stage 12: rounded dividends |T_i| * 2^FO + norm/2
   logic            p12_vld_ff;
   logic [DW-1:0]   p12_d_ff [3];
   logic [NW-1:0]   p12_norm_ff;
   logic [2:0]      p12_neg_ff;
   logic            p12_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p12_vld_ff <= 1'b0;
      end else if (en) begin
         p12_vld_ff <= s2_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p12_norm_ff <= s2_root;
         p12_neg_ff  <= s2_pay.neg;
         p12_zero_ff <= s2_pay.tir || (s2_root == '0);
         for (int i = 0; i < 3; i++) begin
            p12_d_ff[i] <= (DW'(s2_pay.mag[i]) << FO) + DW'(s2_root >> 1);
         end
      end
   end

   // ---- normalizing divider, one quotient bit per stage, three lanes
   logic            dv_vld_ff  [QW];
   logic [NW-1:0]   dv_norm_ff [QW];
   logic [2:0]      dv_neg_ff  [QW];
   logic            dv_zero_ff [QW];
   logic [DW-1:0]   dv_rem_ff  [QW][3];
   logic [QW-1:0]   dv_q_ff    [QW][3];
   logic            dv_tir_ff  [QW];
   logic            p12_tir;

   assign p12_tir = s2_pay.tir;

   // carry the reflection flag alongside the divider stages
   logic            p12_tir_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         p12_tir_ff <= p12_tir;
      end
   end

   for (genvar j = 0; j < QW; j++) begin : g_div
      localparam int B = QW - 1 - j;
      logic          vld_i;
      logic [NW-1:0] norm_i;
      logic [2:0]    neg_i;
      logic          zero_i;
      logic          tir_i;
      logic [DW-1:0] rem_i [3];
      logic [QW-1:0] q_i   [3];
      logic [DW-1:0] test;

      if (j == 0) begin : g_first
         assign vld_i  = p12_vld_ff;
         assign norm_i = p12_norm_ff;
         assign neg_i  = p12_neg_ff;
         assign zero_i = p12_zero_ff;
         assign tir_i  = p12_tir_ff;
         for (genvar l = 0; l < 3; l++) begin : g_lane
            assign rem_i[l] = p12_d_ff[l];
            assign q_i[l]   = '0;
         end
      end else begin : g_next
         assign vld_i  = dv_vld_ff[j-1];
         assign norm_i = dv_norm_ff[j-1];
         assign neg_i  = dv_neg_ff[j-1];
         assign zero_i = dv_zero_ff[j-1];
         assign tir_i  = dv_tir_ff[j-1];
         for (genvar l = 0; l < 3; l++) begin : g_lane
            assign rem_i[l] = dv_rem_ff[j-1][l];
            assign q_i[l]   = dv_q_ff[j-1][l];
         end
      end

      assign test = DW'(norm_i) << B;

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[j] <= 1'b0;
         end else if (en) begin
            dv_vld_ff[j] <= vld_i;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_norm_ff[j] <= norm_i;
            dv_neg_ff[j]  <= neg_i;
            dv_zero_ff[j] <= zero_i;
            dv_tir_ff[j]  <= tir_i;
            for (int l = 0; l < 3; l++) begin
               if (rem_i[l] >= test) begin
                  dv_rem_ff[j][l] <= rem_i[l] - test;
                  dv_q_ff[j][l]   <= q_i[l] | (QW'(1) << B);
               end else begin
                  dv_rem_ff[j][l] <= rem_i[l];
                  dv_q_ff[j][l]   <= q_i[l];
               end
            end
         end
      end
   end

   // ---- output register: sign, saturate, zero on reflection or zero norm
   logic [CB-1:0]    out_c [3];
   logic             rsp_vld_ff;
   logic [RSP_W-1:0] rsp_data_ff;
   logic             rsp_tir_ff;

   for (genvar l = 0; l < 3; l++) begin : g_out
      logic [QW-1:0] qm;
      logic          big;
      assign qm  = dv_q_ff[QW-1][l];
      assign big = qm[QW-1:FO] != '0;
      always_comb begin
         if (dv_zero_ff[QW-1]) begin
            out_c[l] = '0;
         end else if (dv_neg_ff[QW-1][l]) begin
            out_c[l] = big ? {1'b1, {FO{1'b0}}} : CB'(-qm);
         end else begin
            out_c[l] = big ? {1'b0, {FO{1'b1}}} : CB'(qm);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= dv_vld_ff[QW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= RSP_W'({out_c[2], out_c[1], out_c[0]});
         rsp_tir_ff  <= dv_tir_ff[QW-1];
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_tir_ff;

   // ---- checks
   a_tir_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("reflection result carries a nonzero vector");

   a_busy_block: assert property (@(posedge clock) disable iff (reset)
      coef.busy |-> !req_tready)
      else $error("ray taken while eta is being recomputed");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(p1_vld_ff) && $stable(p12_vld_ff))
      else $error("pipeline moved during an output stall");

   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> coef.busy)
      else $error("index write did not start the eta sequence");

endmodule
